### hdl/assert_macros.svh
// Assertion macros shared by the graph traversal RTL.
// Each macro expects i_clk and i_rst_n in the scope where it is used.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property checked at every clock edge outside reset
`define GTU_ASSERT(label, prop, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (prop)) \
        else $error(msg);

// Condition that must never hold outside reset
`define GTU_NEVER(label, cond, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) !(cond)) \
        else $error(msg);

`endif

### hdl/gtu_pkg.sv
// Shared types and sizing constants for the graph traversal unit.
// No dependencies; imported by gtu_obuf and the top level.
package gtu_pkg;

    localparam int NODES       = 32;
    localparam int MAX_DEGREE  = 16;
    localparam int MAX_RESULTS = 32;
    localparam int FIELD_W     = 5;

    localparam int NODE_W    = $clog2(NODES);
    localparam int PTR_W     = $clog2(NODES + 1);
    localparam int DEG_W     = $clog2(MAX_DEGREE + 1);
    localparam int CNT_W     = $clog2(MAX_RESULTS + 1);
    localparam int NBR_DEPTH = NODES * MAX_DEGREE;
    localparam int NBR_AW    = $clog2(NBR_DEPTH);

    typedef enum logic [1:0] {
        MODE_CLEAR = 2'd0,
        MODE_EDGE  = 2'd1,
        MODE_BFS   = 2'd2,
        MODE_DFS   = 2'd3
    } t_mode;

    typedef struct packed {
        t_mode              mode;
        logic [FIELD_W-1:0] node_a;
        logic [FIELD_W-1:0] node_b;
    } t_in_item;

    typedef struct packed {
        logic [FIELD_W-1:0] visited_node;
        logic               last;
        logic               status;
    } t_out_item;

    // result handed from the sequencer to the output register
    typedef struct packed {
        logic      vld;
        t_out_item item;
    } t_obuf_push;

endpackage

### hdl/gtu_ram.sv
// Generic single-write, single-read synchronous RAM with registered read data.
// Read data holds until the next read enable. No dependencies.
module gtu_ram #(
    parameter int  DEPTH = 32,
    parameter int  WIDTH = 5,
    localparam int AW    = $clog2(DEPTH)
) (
    input  logic             i_clk,
    input  logic             i_we,
    input  logic [AW-1:0]    i_waddr,
    input  logic [WIDTH-1:0] i_wdata,
    input  logic             i_re,
    input  logic [AW-1:0]    i_raddr,
    output logic [WIDTH-1:0] o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

### hdl/gtu_obuf.sv
// One-entry output register for result items, parting the sequencer from the
// downstream stall. Depends on gtu_pkg.
module gtu_obuf (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  gtu_pkg::t_obuf_push i_push,
    output logic                o_space,
    output logic                o_out_valid,
    input  logic                i_out_stall,
    output gtu_pkg::t_out_item  o_out_item
);
    import gtu_pkg::*;

    logic      r_vld;
    t_out_item r_item;

    // free now, or emptied at this edge
    assign o_space = !r_vld || !i_out_stall;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= 1'b0;
        end else if (i_push.vld) begin
            r_vld <= 1'b1;
        end else if (!i_out_stall) begin
            r_vld <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push.vld) begin
            r_item <= i_push.item;
        end
    end

    assign o_out_valid = r_vld;
    assign o_out_item  = r_item;

endmodule

### hdl/graph_traversal_bfs_dfs_unit.sv
// Graph traversal unit top level: edge store, breadth/depth-first walk sequencer.
// Depends on gtu_pkg, gtu_ram, gtu_obuf and assert_macros.svh.
//
//   channel  | signals                               | direction
//   ---------+---------------------------------------+----------
//   in       | i_in_valid, o_in_stall, i_in_item     | to block
//   out      | o_out_valid, i_out_stall, o_out_item  | from block
//
// One item at a time. Add edge: read deg(a), check and append at a, append at b,
// acknowledge; a dropped edge skips both appends. Walk: per visited node, pop it,
// then scan its neighbours with one neighbour-store read a cycle.
// Synchronous active-low reset clears degrees, visited marks and pointers; no
// clearing pass. A full output register holds the sequencer in place.
`include "assert_macros.svh"

module graph_traversal_bfs_dfs_unit (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_in_valid,
    output logic               o_in_stall,
    input  gtu_pkg::t_in_item  i_in_item,
    output logic               o_out_valid,
    input  logic               i_out_stall,
    output gtu_pkg::t_out_item o_out_item
);
    import gtu_pkg::*;

    typedef enum logic [8:0] {
        S_IDLE   = 9'b000000001,
        S_ACK    = 9'b000000010,
        S_EDGE_A = 9'b000000100,
        S_EDGE_B = 9'b000001000,
        S_EDGE_W = 9'b000010000,
        S_POP    = 9'b000100000,
        S_POPD   = 9'b001000000,
        S_SCAN   = 9'b010000000,
        S_FIN    = 9'b100000000
    } t_state;

    function automatic logic [NBR_AW-1:0] nbr_addr(input logic [NODE_W-1:0] node,
                                                   input logic [DEG_W-1:0]  slot);
        return NBR_AW'(node) * NBR_AW'(MAX_DEGREE) + NBR_AW'(slot);
    endfunction

    t_state             r_state, n_state;
    t_mode              r_mode, n_mode;
    logic [FIELD_W-1:0] r_a, n_a;
    logic [FIELD_W-1:0] r_b, n_b;
    logic [DEG_W-1:0]   r_da, n_da;
    logic               r_status, n_status;
    logic [PTR_W-1:0]   r_head, n_head;
    logic [PTR_W-1:0]   r_tail, n_tail;
    logic [NODE_W-1:0]  r_node, n_node;
    logic [DEG_W-1:0]   r_i, n_i;
    logic               r_chk, n_chk;
    logic [FIELD_W-1:0] r_pend, n_pend;
    logic               r_have_pend, n_have_pend;
    logic [CNT_W-1:0]   r_cnt, n_cnt;

    // degree counts with per-node valid bits, visited marks
    logic [DEG_W-1:0]   r_deg [NODES];
    logic [NODES-1:0]   r_deg_vld;
    logic [NODES-1:0]   r_visited;

    logic               in_acc;
    logic [NODE_W-1:0]  deg_raddr;
    logic [DEG_W-1:0]   deg_rd;
    logic               deg_we;
    logic [NODE_W-1:0]  deg_waddr;
    logic [DEG_W-1:0]   deg_wdata;
    logic               deg_clr;
    logic               vis_init;
    logic               vis_set;
    logic [NODE_W-1:0]  vis_addr;
    logic               drop;
    logic               wl_empty;
    logic               pop_stop;
    logic               scan_issue;
    logic               nxt_new;

    logic               nbr_we, nbr_re;
    logic [NBR_AW-1:0]  nbr_waddr, nbr_raddr;
    logic [FIELD_W-1:0] nbr_wdata, nbr_rdata;
    logic               wl_we, wl_re;
    logic [NODE_W-1:0]  wl_waddr, wl_raddr;
    logic [FIELD_W-1:0] wl_wdata, wl_rdata;

    t_obuf_push         obuf_push;
    logic               obuf_space;

    assign o_in_stall = (r_state != S_IDLE) || !i_rst_n;
    assign in_acc     = i_in_valid && !o_in_stall;

    always_comb begin
        priority case (r_state)
            S_EDGE_A: deg_raddr = NODE_W'(r_a);
            S_SCAN:   deg_raddr = r_node;
            default:  deg_raddr = NODE_W'(r_b);
        endcase
    end

    assign deg_rd = r_deg_vld[deg_raddr] ? r_deg[deg_raddr] : '0;

    // r_da holds deg(a), deg_rd holds deg(b); a self loop needs two slots
    always_comb begin
        if (32'(r_a) >= NODES || 32'(r_b) >= NODES) begin
            drop = 1'b1;
        end else if (r_a == r_b) begin
            drop = (32'(r_da) + 2) > MAX_DEGREE;
        end else begin
            drop = (32'(r_da) >= MAX_DEGREE) || (32'(deg_rd) >= MAX_DEGREE);
        end
    end

    assign wl_empty   = (r_mode == MODE_DFS) ? (r_tail == '0) : (r_head == r_tail);
    assign pop_stop   = (32'(wl_rdata) >= NODES) || (32'(r_cnt) >= MAX_RESULTS);
    assign scan_issue = r_i < deg_rd;
    assign nxt_new    = (32'(nbr_rdata) < NODES) && !r_visited[NODE_W'(nbr_rdata)]
                        && (32'(r_tail) < NODES);

    always_comb begin
        n_state     = r_state;
        n_mode      = r_mode;
        n_a         = r_a;
        n_b         = r_b;
        n_da        = r_da;
        n_status    = r_status;
        n_head      = r_head;
        n_tail      = r_tail;
        n_node      = r_node;
        n_i         = r_i;
        n_chk       = r_chk;
        n_pend      = r_pend;
        n_have_pend = r_have_pend;
        n_cnt       = r_cnt;
        deg_we      = 1'b0;
        deg_waddr   = NODE_W'(r_a);
        deg_wdata   = DEG_W'(r_da + DEG_W'(1));
        deg_clr     = 1'b0;
        vis_init    = 1'b0;
        vis_set     = 1'b0;
        vis_addr    = NODE_W'(nbr_rdata);
        nbr_we      = 1'b0;
        nbr_waddr   = nbr_addr(NODE_W'(r_a), r_da);
        nbr_wdata   = r_b;
        nbr_re      = 1'b0;
        nbr_raddr   = nbr_addr(r_node, r_i);
        wl_we       = 1'b0;
        wl_waddr    = r_tail[NODE_W-1:0];
        wl_wdata    = nbr_rdata;
        wl_re       = 1'b0;
        wl_raddr    = r_head[NODE_W-1:0];
        obuf_push   = '0;

        unique case (r_state)
            S_IDLE: begin
                if (in_acc) begin
                    n_mode = i_in_item.mode;
                    n_a    = i_in_item.node_a;
                    n_b    = i_in_item.node_b;
                    unique case (i_in_item.mode)
                        MODE_CLEAR: begin
                            deg_clr  = 1'b1;
                            n_status = 1'b0;
                            n_state  = S_ACK;
                        end
                        MODE_EDGE: begin
                            n_state = S_EDGE_A;
                        end
                        MODE_BFS, MODE_DFS: begin
                            n_have_pend = 1'b0;
                            n_cnt       = '0;
                            if (32'(i_in_item.node_a) < NODES) begin
                                vis_init = 1'b1;
                                vis_addr = NODE_W'(i_in_item.node_a);
                                wl_we    = 1'b1;
                                wl_waddr = '0;
                                wl_wdata = i_in_item.node_a;
                                n_head   = '0;
                                n_tail   = PTR_W'(1);
                                n_state  = S_POP;
                            end else begin
                                n_state = S_FIN;
                            end
                        end
                        default: n_state = S_IDLE;
                    endcase
                end
            end
            S_EDGE_A: begin
                n_da    = deg_rd;
                n_state = S_EDGE_B;
            end
            S_EDGE_B: begin
                if (drop) begin
                    n_status = 1'b1;
                    n_state  = S_ACK;
                end else begin
                    nbr_we  = 1'b1;
                    deg_we  = 1'b1;
                    n_state = S_EDGE_W;
                end
            end
            S_EDGE_W: begin
                // deg(b) re-read here so a self loop sees the first append
                nbr_we    = 1'b1;
                nbr_waddr = nbr_addr(NODE_W'(r_b), deg_rd);
                nbr_wdata = r_a;
                deg_we    = 1'b1;
                deg_waddr = NODE_W'(r_b);
                deg_wdata = DEG_W'(deg_rd + DEG_W'(1));
                n_status  = 1'b0;
                n_state   = S_ACK;
            end
            S_ACK: begin
                if (obuf_space) begin
                    obuf_push.vld               = 1'b1;
                    obuf_push.item.visited_node = '0;
                    obuf_push.item.last         = 1'b1;
                    obuf_push.item.status       = r_status;
                    n_state                     = S_IDLE;
                end
            end
            S_POP: begin
                if (wl_empty) begin
                    n_state = S_FIN;
                end else begin
                    wl_re = 1'b1;
                    if (r_mode == MODE_DFS) begin
                        n_tail   = PTR_W'(r_tail - PTR_W'(1));
                        wl_raddr = n_tail[NODE_W-1:0];
                    end else begin
                        n_head   = PTR_W'(r_head + PTR_W'(1));
                        wl_raddr = r_head[NODE_W-1:0];
                    end
                    n_state = S_POPD;
                end
            end
            S_POPD: begin
                if (pop_stop) begin
                    n_state = S_FIN;
                end else if (!r_have_pend || obuf_space) begin
                    // previous node is not the last one: release it now
                    obuf_push.vld               = r_have_pend;
                    obuf_push.item.visited_node = r_pend;
                    n_pend      = wl_rdata;
                    n_have_pend = 1'b1;
                    n_cnt       = CNT_W'(r_cnt + CNT_W'(1));
                    n_node      = NODE_W'(wl_rdata);
                    n_i         = '0;
                    n_chk       = 1'b0;
                    n_state     = S_SCAN;
                end
            end
            S_SCAN: begin
                // issue read i while checking the neighbour read last cycle
                if (r_chk && nxt_new) begin
                    vis_set = 1'b1;
                    wl_we   = 1'b1;
                    n_tail  = PTR_W'(r_tail + PTR_W'(1));
                end
                if (scan_issue) begin
                    nbr_re = 1'b1;
                    n_i    = DEG_W'(r_i + DEG_W'(1));
                    n_chk  = 1'b1;
                end else begin
                    n_chk = 1'b0;
                    if (!r_chk) begin
                        n_state = S_POP;
                    end
                end
            end
            S_FIN: begin
                if (!r_have_pend) begin
                    n_state = S_IDLE;
                end else if (obuf_space) begin
                    obuf_push.vld               = 1'b1;
                    obuf_push.item.visited_node = r_pend;
                    obuf_push.item.last         = 1'b1;
                    n_have_pend                 = 1'b0;
                    n_state                     = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_mode      <= MODE_CLEAR;
            r_head      <= '0;
            r_tail      <= '0;
            r_have_pend <= 1'b0;
            r_chk       <= 1'b0;
            r_deg_vld   <= '0;
            r_visited   <= '0;
        end else begin
            r_state     <= n_state;
            r_mode      <= n_mode;
            r_head      <= n_head;
            r_tail      <= n_tail;
            r_have_pend <= n_have_pend;
            r_chk       <= n_chk;
            if (deg_clr) begin
                r_deg_vld <= '0;
            end else if (deg_we) begin
                r_deg_vld[deg_waddr] <= 1'b1;
            end
            // a new walk keeps only the start node marked
            if (vis_init) begin
                r_visited <= NODES'(1) << vis_addr;
            end else if (vis_set) begin
                r_visited[vis_addr] <= 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_a      <= n_a;
        r_b      <= n_b;
        r_da     <= n_da;
        r_status <= n_status;
        r_node   <= n_node;
        r_i      <= n_i;
        r_pend   <= n_pend;
        r_cnt    <= n_cnt;
        if (deg_we) begin
            r_deg[deg_waddr] <= deg_wdata;
        end
    end

    gtu_ram #(
        .DEPTH (NBR_DEPTH),
        .WIDTH (FIELD_W)
    ) u_nbr_ram (
        .i_clk   (i_clk),
        .i_we    (nbr_we),
        .i_waddr (nbr_waddr),
        .i_wdata (nbr_wdata),
        .i_re    (nbr_re),
        .i_raddr (nbr_raddr),
        .o_rdata (nbr_rdata)
    );

    gtu_ram #(
        .DEPTH (NODES),
        .WIDTH (FIELD_W)
    ) u_wl_ram (
        .i_clk   (i_clk),
        .i_we    (wl_we),
        .i_waddr (wl_waddr),
        .i_wdata (wl_wdata),
        .i_re    (wl_re),
        .i_raddr (wl_raddr),
        .o_rdata (wl_rdata)
    );

    gtu_obuf u_obuf (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_push      (obuf_push),
        .o_space     (obuf_space),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_out_item  (o_out_item)
    );

    `GTU_ASSERT(a_push_has_room, obuf_push.vld |-> obuf_space, "item pushed into full output register")
    `GTU_ASSERT(a_tail_bound, 32'(r_tail) <= NODES, "work list overflow")
    `GTU_ASSERT(a_bfs_order, (r_mode == MODE_BFS) |-> (r_head <= r_tail), "queue head passed tail")
    `GTU_ASSERT(a_accept_busy, (i_in_valid && !o_in_stall) |=> o_in_stall, "item accepted twice")
    `GTU_NEVER(a_mid_walk_item, obuf_push.vld && !obuf_push.item.last && (r_state != S_POPD), "unflagged item outside walk")

endmodule
